>>> src/prrts_pkg.sv
package prrts_pkg;

    typedef enum logic [2:0] {
        SS_UNUSED   = 3'd0,
        SS_READY    = 3'd1,
        SS_RUNNING  = 3'd2,
        SS_SLEEPING = 3'd3,
        SS_EXITED   = 3'd4
    } slot_st_t;

    typedef enum logic [2:0] {
        FN_TICK   = 3'd0,
        FN_CREATE = 3'd1,
        FN_SLEEP  = 3'd2,
        FN_EXIT   = 3'd3,
        FN_KILL   = 3'd4
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_CREATE,
        S_RD,
        S_EVAL,
        S_ACCT,
        S_PICK,
        S_MUL,
        S_DIV,
        S_DONE
    } fsm_t;

    localparam logic [1:0] PRIO_HIGH   = 2'd0;
    localparam logic [1:0] PRIO_NORMAL = 2'd1;
    localparam logic [1:0] PRIO_LOW    = 2'd2;
    localparam logic [1:0] PRIO_IDLE   = 2'd3;

    localparam logic [1:0] REG_STARV  = 2'd0;
    localparam logic [1:0] REG_WINDOW = 2'd1;
    localparam logic [1:0] REG_MINWIN = 2'd2;

    localparam logic [15:0] STARV_RST  = 16'd250;
    localparam logic [15:0] WINDOW_RST = 16'd250;
    localparam logic [15:0] MINWIN_RST = 16'd50;
    localparam logic [6:0]  PERCENT    = 7'd100;

    localparam int NUM_W = 23;

endpackage

>>> src/prrts_div.sv
module prrts_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [prrts_pkg::NUM_W-1:0]   num,
    input  logic [15:0]                   den,
    output logic                          done,
    output logic [6:0]                    quot
);

    logic [prrts_pkg::NUM_W-1:0] num_reg;
    logic [prrts_pkg::NUM_W-1:0] q_reg;
    logic [15:0]                 den_reg;
    logic [16:0]                 rem_reg;
    logic [4:0]                  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [16:0]                 shifted;
    logic                        fits;

    // one quotient bit per cycle, restoring
    assign shifted = {rem_reg[15:0], num_reg[prrts_pkg::NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(prrts_pkg::NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[prrts_pkg::NUM_W-2:0], 1'b0};
            rem_reg <= fits ? (shifted - {1'b0, den_reg}) : shifted;
            q_reg   <= {q_reg[prrts_pkg::NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg[6:0];

endmodule

>>> src/priority_round_robin_task_scheduler.sv
// Sequence: a tick, sleep or exit reads and evaluates every slot (S_RD, S_EVAL), accounts (S_ACCT),
//   scans up to SLOTS slots per priority level (S_PICK) and computes usage (S_MUL, S_DIV). Create
//   scans for an unused slot first; kill, and sleep or exit from the idle task, go straight to usage.
// Throughput: one item at a time; s_axis_tready is high only when the sequencer is idle.
// Reset (rst_n, async low): slot 0 running at normal priority, slot 1 idle task ready,
//   other slots unused, window counters and round-robin pointers zero, registers at defaults.
module priority_round_robin_task_scheduler #(
    parameter int SLOTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [2:0] func, [4:3] priority_req, [8:5] task_id, [40:9] sleep_ticks, [104:41] now
    input  logic [111:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [0] status, [4:1] next_task, [5] switched, [9:6] new_task_id,
    // [16:10] cpu_usage, [21:17] live_tasks
    output logic [23:0]   m_axis_tdata,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_idx,
    input  logic [15:0]   cfg_wdata
);

    localparam int IW = $clog2(SLOTS);
    localparam int XW = (IW > 4) ? IW : 4;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] IDLE_SLOT = IW'(1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

    prrts_pkg::fsm_t     state_reg, state_next;

    // captured item
    logic [2:0]          func_reg;
    logic [1:0]          prio_reg;
    logic [3:0]          id_reg;
    logic [31:0]         ticks_reg;
    logic [63:0]         now_reg;

    // per-slot state
    prrts_pkg::slot_st_t stat_reg [SLOTS];
    logic [1:0]          base_reg [SLOTS];
    logic [SLOTS-1:0]    lrt_vld_reg;
    logic [SLOTS-1:0]    rdy_vec_reg;
    logic [1:0]          lvl_vec_reg [SLOTS];
    logic [63:0]         wake_mem [SLOTS];
    logic [31:0]         lrt_mem [SLOTS];
    logic [63:0]         wake_rd_reg;
    logic [31:0]         lrt_rd_reg;

    logic [IW-1:0]       rot_reg [4];
    logic [IW-1:0]       run_reg;
    logic [IW-1:0]       before_reg;
    logic [CW-1:0]       inuse_reg;
    logic [15:0]         win_reg, idl_reg, pwin_reg, pidl_reg;
    logic [15:0]         starv_reg, window_reg, minwin_reg;

    // sequencer
    logic [IW-1:0]       idx_reg;
    logic [IW-1:0]       cnt_reg;
    logic [1:0]          lvl_reg;
    logic                rej_reg;
    logic [IW-1:0]       new_id_reg;
    logic [6:0]          usage_reg;

    logic                m_valid_reg;
    logic [23:0]         m_data_reg;

    // shared divider; operands are stable while in S_MUL, where it is started
    logic                div_start;
    logic                div_done;
    logic [6:0]          div_quot;
    logic [prrts_pkg::NUM_W-1:0] div_num;
    logic [15:0]         div_den;

    prrts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ---------------------------------------------------------------
    // combinational helpers
    // ---------------------------------------------------------------
    logic [IW-1:0]       idx_inc;
    prrts_pkg::slot_st_t cur_st, new_st;
    logic                boost;
    logic [31:0]         lrt_val;
    logic [31:0]         delta;
    logic                pick_hit;
    logic [XW-1:0]       kill_x;
    logic [IW-1:0]       kill_i;
    logic                kill_bad;
    logic                use_prev;
    logic [15:0]         u_w, u_i, u_ic;
    logic [15:0]         win_inc;
    logic                out_free;
    logic [31:0]         sleep_len;
    logic [XW-1:0]       run_x, new_x;

    assign idx_inc = (idx_reg == LAST_SLOT) ? '0 : idx_reg + IW'(1);
    assign cur_st  = stat_reg[idx_reg];

    always_comb
    begin
        new_st = cur_st;
        if (cur_st == prrts_pkg::SS_SLEEPING && now_reg >= wake_rd_reg)
            new_st = prrts_pkg::SS_READY;
        else if (cur_st == prrts_pkg::SS_EXITED)
            new_st = prrts_pkg::SS_UNUSED;
    end

    // the running slot's last run time is refreshed to now during the slot pass
    assign lrt_val = (idx_reg == run_reg) ? now_reg[31:0]
                   : (lrt_vld_reg[idx_reg] ? lrt_rd_reg : 32'd0);
    assign delta   = now_reg[31:0] - lrt_val;
    assign boost   = (new_st == prrts_pkg::SS_READY)
                   && (base_reg[idx_reg] == prrts_pkg::PRIO_NORMAL
                       || base_reg[idx_reg] == prrts_pkg::PRIO_LOW)
                   && (delta >= {16'd0, starv_reg});

    assign pick_hit = rdy_vec_reg[idx_reg] && (lvl_vec_reg[idx_reg] == lvl_reg);

    assign kill_x   = XW'(id_reg);
    assign kill_i   = kill_x[IW-1:0];
    assign kill_bad = (id_reg == 4'd0) || (id_reg == 4'd1)
                   || (32'(id_reg) >= SLOTS)
                   || (stat_reg[kill_i] == prrts_pkg::SS_UNUSED);

    assign use_prev = win_reg < minwin_reg;
    assign u_w      = use_prev ? pwin_reg : win_reg;
    assign u_i      = use_prev ? pidl_reg : idl_reg;
    assign u_ic     = (u_i > u_w) ? u_w : u_i;
    assign win_inc  = win_reg + 16'd1;

    assign div_num  = prrts_pkg::NUM_W'(u_w - u_ic)
                    * prrts_pkg::NUM_W'(prrts_pkg::PERCENT);
    assign div_den  = u_w;

    assign sleep_len = (ticks_reg == 32'd0) ? 32'd1 : ticks_reg;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign div_start = (state_reg == prrts_pkg::S_MUL) && (u_w != 16'd0);

    assign run_x = XW'(run_reg);
    assign new_x = XW'(new_id_reg);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= prrts_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prrts_pkg::S_IDLE:
                if (s_axis_tvalid)
                    state_next = prrts_pkg::S_START;
            prrts_pkg::S_START:
                priority case (func_reg)
                    prrts_pkg::FN_TICK:   state_next = prrts_pkg::S_RD;
                    prrts_pkg::FN_CREATE: state_next = prrts_pkg::S_CREATE;
                    prrts_pkg::FN_SLEEP,
                    prrts_pkg::FN_EXIT:
                        state_next = (run_reg == IDLE_SLOT) ? prrts_pkg::S_MUL
                                                            : prrts_pkg::S_RD;
                    default:              state_next = prrts_pkg::S_MUL;
                endcase
            prrts_pkg::S_CREATE:
                if (cur_st == prrts_pkg::SS_UNUSED || idx_reg == LAST_SLOT)
                    state_next = prrts_pkg::S_MUL;
            prrts_pkg::S_RD:
                state_next = prrts_pkg::S_EVAL;
            prrts_pkg::S_EVAL:
                state_next = (idx_reg == LAST_SLOT) ? prrts_pkg::S_ACCT : prrts_pkg::S_RD;
            prrts_pkg::S_ACCT:
                state_next = prrts_pkg::S_PICK;
            prrts_pkg::S_PICK:
                if (pick_hit || (cnt_reg == LAST_SLOT && lvl_reg == prrts_pkg::PRIO_IDLE))
                    state_next = prrts_pkg::S_MUL;
            prrts_pkg::S_MUL:
                state_next = (u_w == 16'd0) ? prrts_pkg::S_DONE : prrts_pkg::S_DIV;
            prrts_pkg::S_DIV:
                if (div_done)
                    state_next = prrts_pkg::S_DONE;
            prrts_pkg::S_DONE:
                if (out_free)
                    state_next = prrts_pkg::S_IDLE;
            default:
                state_next = prrts_pkg::S_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == prrts_pkg::S_IDLE);

    // ---------------------------------------------------------------
    // memories: wake deadlines and last run times
    // ---------------------------------------------------------------
    logic          wake_we;
    logic [IW-1:0] wake_wa;
    logic [63:0]   wake_wd;
    logic          lrt_we;

    always_comb
    begin
        wake_we = 1'b0;
        wake_wa = run_reg;
        wake_wd = now_reg + {32'd0, sleep_len};
        if (state_reg == prrts_pkg::S_CREATE && cur_st == prrts_pkg::SS_UNUSED)
        begin
            wake_we = 1'b1;
            wake_wa = idx_reg;
            wake_wd = '0;
        end
        else if (state_reg == prrts_pkg::S_START && func_reg == prrts_pkg::FN_SLEEP
                 && run_reg != IDLE_SLOT && stat_reg[run_reg] == prrts_pkg::SS_RUNNING)
            wake_we = 1'b1;
    end

    assign lrt_we = (state_reg == prrts_pkg::S_EVAL) && (idx_reg == run_reg);

    always_ff @(posedge clk)
    begin
        if (wake_we)
            wake_mem[wake_wa] <= wake_wd;
        if (lrt_we)
            lrt_mem[run_reg] <= now_reg[31:0];
        if (state_reg == prrts_pkg::S_RD)
        begin
            wake_rd_reg <= wake_mem[idx_reg];
            lrt_rd_reg  <= lrt_mem[idx_reg];
        end
    end

    // ---------------------------------------------------------------
    // payload capture and work registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == prrts_pkg::S_IDLE && s_axis_tvalid)
        begin
            func_reg  <= s_axis_tdata[2:0];
            prio_reg  <= s_axis_tdata[4:3];
            id_reg    <= s_axis_tdata[8:5];
            ticks_reg <= s_axis_tdata[40:9];
            now_reg   <= s_axis_tdata[104:41];
        end
        if (state_reg == prrts_pkg::S_EVAL)
        begin
            rdy_vec_reg[idx_reg] <= (new_st == prrts_pkg::SS_READY);
            lvl_vec_reg[idx_reg] <= boost ? prrts_pkg::PRIO_HIGH : base_reg[idx_reg];
        end
        if (state_reg == prrts_pkg::S_ACCT && stat_reg[run_reg] == prrts_pkg::SS_RUNNING)
        begin
            rdy_vec_reg[run_reg] <= 1'b1;
            lvl_vec_reg[run_reg] <= base_reg[run_reg];
        end
    end

    // ---------------------------------------------------------------
    // scheduler state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                stat_reg[i] <= (i == 0) ? prrts_pkg::SS_RUNNING
                             : (i == 1) ? prrts_pkg::SS_READY : prrts_pkg::SS_UNUSED;
                base_reg[i] <= (i == 0) ? prrts_pkg::PRIO_NORMAL
                             : (i == 1) ? prrts_pkg::PRIO_IDLE : prrts_pkg::PRIO_HIGH;
            end
            for (int p = 0; p < 4; p++)
                rot_reg[p] <= '0;
            lrt_vld_reg <= '0;
            run_reg     <= '0;
            before_reg  <= '0;
            inuse_reg   <= CW'(2);
            win_reg     <= '0;
            idl_reg     <= '0;
            pwin_reg    <= '0;
            pidl_reg    <= '0;
            starv_reg   <= prrts_pkg::STARV_RST;
            window_reg  <= prrts_pkg::WINDOW_RST;
            minwin_reg  <= prrts_pkg::MINWIN_RST;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            lvl_reg     <= '0;
            rej_reg     <= 1'b0;
            new_id_reg  <= '0;
            usage_reg   <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    prrts_pkg::REG_STARV:  starv_reg  <= cfg_wdata;
                    prrts_pkg::REG_WINDOW: window_reg <= cfg_wdata;
                    prrts_pkg::REG_MINWIN: minwin_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            // S_DONE loads the next result itself
            if (m_axis_tready && state_reg != prrts_pkg::S_DONE)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                prrts_pkg::S_IDLE:
                begin
                    before_reg <= run_reg;
                    rej_reg    <= 1'b0;
                    new_id_reg <= '0;
                    idx_reg    <= '0;
                end
                prrts_pkg::S_START:
                begin
                    priority case (func_reg)
                        prrts_pkg::FN_SLEEP,
                        prrts_pkg::FN_EXIT:
                            if (run_reg == IDLE_SLOT)
                                rej_reg <= 1'b1;
                            else if (stat_reg[run_reg] == prrts_pkg::SS_RUNNING)
                                stat_reg[run_reg] <= (func_reg == prrts_pkg::FN_SLEEP)
                                                   ? prrts_pkg::SS_SLEEPING
                                                   : prrts_pkg::SS_EXITED;
                        prrts_pkg::FN_KILL:
                            if (kill_bad)
                                rej_reg <= 1'b1;
                            else
                                stat_reg[kill_i] <= prrts_pkg::SS_EXITED;
                        default: ;
                    endcase
                end
                prrts_pkg::S_CREATE:
                begin
                    if (cur_st == prrts_pkg::SS_UNUSED)
                    begin
                        stat_reg[idx_reg] <= prrts_pkg::SS_READY;
                        base_reg[idx_reg] <= prio_reg;
                        inuse_reg         <= inuse_reg + CW'(1);
                        new_id_reg        <= idx_reg;
                    end
                    else if (idx_reg == LAST_SLOT)
                        rej_reg <= 1'b1;
                    else
                        idx_reg <= idx_inc;
                end
                prrts_pkg::S_RD: ;
                prrts_pkg::S_EVAL:
                begin
                    stat_reg[idx_reg] <= new_st;
                    if (cur_st == prrts_pkg::SS_EXITED && inuse_reg != '0)
                        inuse_reg <= inuse_reg - CW'(1);
                    if (lrt_we)
                        lrt_vld_reg[run_reg] <= 1'b1;
                    idx_reg <= idx_inc;
                end
                prrts_pkg::S_ACCT:
                begin
                    // close the accounting window once it reaches its length
                    if (win_inc >= window_reg)
                    begin
                        pwin_reg <= win_inc;
                        pidl_reg <= idl_reg + ((run_reg == IDLE_SLOT) ? 16'd1 : 16'd0);
                        win_reg  <= '0;
                        idl_reg  <= '0;
                    end
                    else
                    begin
                        win_reg <= win_inc;
                        if (run_reg == IDLE_SLOT)
                            idl_reg <= idl_reg + 16'd1;
                    end
                    if (stat_reg[run_reg] == prrts_pkg::SS_RUNNING)
                        stat_reg[run_reg] <= prrts_pkg::SS_READY;
                    lvl_reg <= prrts_pkg::PRIO_HIGH;
                    idx_reg <= rot_reg[0];
                    cnt_reg <= '0;
                end
                prrts_pkg::S_PICK:
                begin
                    if (pick_hit)
                    begin
                        rot_reg[lvl_reg]  <= idx_inc;
                        stat_reg[idx_reg] <= prrts_pkg::SS_RUNNING;
                        run_reg           <= idx_reg;
                    end
                    else if (cnt_reg == LAST_SLOT)
                    begin
                        if (lvl_reg == prrts_pkg::PRIO_IDLE)
                        begin
                            stat_reg[IDLE_SLOT] <= prrts_pkg::SS_RUNNING;
                            run_reg             <= IDLE_SLOT;
                        end
                        else
                        begin
                            lvl_reg <= lvl_reg + 2'd1;
                            idx_reg <= rot_reg[lvl_reg + 2'd1];
                            cnt_reg <= '0;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                        cnt_reg <= cnt_reg + IW'(1);
                    end
                end
                prrts_pkg::S_MUL:
                    usage_reg <= '0;
                prrts_pkg::S_DIV:
                    if (div_done)
                        usage_reg <= div_quot;
                prrts_pkg::S_DONE:
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {2'b00, 5'(inuse_reg),
                                        usage_reg, new_x[3:0],
                                        (run_reg != before_reg), run_x[3:0], rej_reg};
                    end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

>>> src/prrts_chk.sv
module prrts_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [23:0]  m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // busy percent never above 100
    a_usage: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:10] <= 7'd100)
        else $error("cpu usage out of range");

    // a rejected item never switches slots
    a_rej: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[5])
        else $error("rejected item switched task");

endmodule

bind priority_round_robin_task_scheduler prrts_chk u_prrts_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
